/* hw/rtl/sha256_pkg.sv */
// Package: SHA-256 round constants, initial hash words, command/status types.
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned BlkBytes = 64;
  localparam int unsigned LenPos  = 56;
  localparam logic [7:0]  PadByte = 8'h80;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // write source for the block buffer
  typedef enum logic [1:0] {
    BufMsg  = 2'd0,
    BufPad  = 2'd1,
    BufZero = 2'd2,
    BufLen  = 2'd3
  } buf_src_e;

  typedef struct packed {
    logic     buf_we;     // write one byte at fill position, advance it
    buf_src_e buf_src;
    logic     cnt_inc;    // count a message byte
    logic     blk_start;  // load working vars from chain
    logic     round_en;   // run one round
    logic     blk_done;   // add working vars into chain
    logic     out_shift;  // rotate chain for output
    logic     clear;      // return to reset state
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;    // fill position is 63
    logic fill_pre_len; // fill position is 55
    logic round_last;   // round 63 in progress
  } dp_sts_t;

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* hw/rtl/sha256_message_hasher_core.sv */
// Top level: SHA-256 message hasher, byte stream in, digest words out.
//  channel | dir | fields
//  s_axis  | in  | tdata: message_byte[7:0]; tuser: has_byte[0]; tlast: end_of_message
//  m_axis  | out | tdata: digest_word[31:0]; tuser: word_index[2:0]; tlast: last_word
// Byte beats are taken in the idle state; every 64th byte starts a compression (64 rounds,
// then chain update) during which input stalls. End of message: padding writes one byte
// per cycle up to the block end, with one or two compressions, then 8 output beats. Input stalls until done.
// Reset loads the chain with the initial hash and clears counters and control; buffers hold no reset.
module sha256_message_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // message_byte
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast    // last_word
);
  import sha256_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .has_byte_i  (s_axis_tuser),
    .eom_i       (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_idx_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sha256_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .byte_i (s_axis_tdata),
    .sts_o  (sts),
    .head_o (m_axis_tdata)
  );

endmodule

/* hw/rtl/sha256_datapath.sv */
// Datapath: block buffer, schedule window, round logic, chain value, byte count.
module sha256_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha256_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]          byte_i,
  output sha256_pkg::dp_sts_t sts_o,
  output logic [31:0]         head_o
);
  import sha256_pkg::*;

  logic [31:0] buf_q [BlkBytes/4];
  logic [31:0] win_q [16];
  logic [31:0] chain_q [8];
  logic [31:0] var_q [8];
  logic [5:0]  fill_q;
  logic [5:0]  rnd_q;
  logic [60:0] total_q;
  logic [63:0] bit_len;
  logic [7:0]  wr_byte;
  logic [31:0] w, t1, t2, e, a;

  assign bit_len = {total_q, 3'b000};

  always_comb begin
    unique case (cmd_i.buf_src)
      BufMsg:  wr_byte = byte_i;
      BufPad:  wr_byte = PadByte;
      BufZero: wr_byte = 8'h00;
      BufLen:  wr_byte = bit_len[8*(7 - {29'd0, fill_q[2:0]}) +: 8];
      default: wr_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (rnd_q < 6'd16) begin
      w = buf_q[rnd_q[3:0]];
    end else begin
      w = (rotr(win_q[rnd_q[3:0] - 4'd2], 17) ^ rotr(win_q[rnd_q[3:0] - 4'd2], 19)
           ^ (win_q[rnd_q[3:0] - 4'd2] >> 10))
        + win_q[rnd_q[3:0] - 4'd7]
        + (rotr(win_q[rnd_q[3:0] - 4'd15], 7) ^ rotr(win_q[rnd_q[3:0] - 4'd15], 18)
           ^ (win_q[rnd_q[3:0] - 4'd15] >> 3))
        + win_q[rnd_q[3:0]];
    end
    e  = var_q[4];
    a  = var_q[0];
    t1 = var_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & var_q[5]) ^ (~e & var_q[6])) + RoundK[rnd_q] + w;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & var_q[1]) ^ (a & var_q[2]) ^ (var_q[1] & var_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_we) begin
      buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (cmd_i.round_en) begin
      win_q[rnd_q[3:0]] <= w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= InitHash[i];
        var_q[i]   <= '0;
      end
      fill_q  <= '0;
      rnd_q   <= '0;
      total_q <= '0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= InitHash[i];
        var_q[i]   <= '0;
      end
      fill_q  <= '0;
      rnd_q   <= '0;
      total_q <= '0;
    end else begin
      if (cmd_i.buf_we) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.cnt_inc) begin
        total_q <= total_q + 61'd1;
      end
      if (cmd_i.blk_start) begin
        for (int i = 0; i < 8; i++) begin
          var_q[i] <= chain_q[i];
        end
        rnd_q <= '0;
      end else if (cmd_i.round_en) begin
        for (int i = 1; i < 8; i++) begin
          var_q[i] <= var_q[i-1];
        end
        var_q[4] <= var_q[3] + t1;
        var_q[0] <= t1 + t2;
        rnd_q    <= rnd_q + 6'd1;
      end
      if (cmd_i.blk_done) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + var_q[i];
        end
      end else if (cmd_i.out_shift) begin
        for (int i = 0; i < 7; i++) begin
          chain_q[i] <= chain_q[i+1];
        end
        chain_q[7] <= chain_q[0];
      end
    end
  end

  assign sts_o.fill_last    = (fill_q == 6'(BlkBytes - 1));
  assign sts_o.fill_pre_len = (fill_q == 6'(LenPos - 1));
  assign sts_o.round_last   = (rnd_q == 6'(Rounds - 1));
  assign head_o = chain_q[0];

endmodule

/* hw/rtl/sha256_ctrl.sv */
// Controller: sequences byte intake, padding, compression and digest output.
module sha256_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                has_byte_i,
  input  logic                eom_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          out_idx_o,
  output logic                out_last_o,
  output sha256_pkg::dp_cmd_t cmd_o,
  input  sha256_pkg::dp_sts_t sts_i
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StMsgComp, StDone, StPad, StZero, StLen, StFinComp, StOut
  } state_e;

  state_e     state_q;
  logic       eom_q;
  logic       fin_q;     // compression ends in digest output
  logic       zero_q;    // compression of a pad overflow block
  logic [2:0] idx_q;
  logic       accept;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign out_idx_o   = idx_q;
  assign out_last_o  = (idx_q == 3'd7);

  always_comb begin
    cmd_o = '0;
    cmd_o.buf_src = BufMsg;
    unique case (state_q)
      StIdle: begin
        if (accept && has_byte_i) begin
          cmd_o.buf_we    = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
          cmd_o.blk_start = sts_i.fill_last;
        end
      end
      StMsgComp, StFinComp: begin
        cmd_o.round_en = 1'b1;
      end
      StDone: begin
        cmd_o.blk_done = 1'b1;
      end
      StPad: begin
        cmd_o.buf_we    = 1'b1;
        cmd_o.buf_src   = BufPad;
        cmd_o.blk_start = sts_i.fill_last;
      end
      StZero: begin
        cmd_o.buf_we    = 1'b1;
        cmd_o.buf_src   = BufZero;
        cmd_o.blk_start = sts_i.fill_last;
      end
      StLen: begin
        cmd_o.buf_we    = 1'b1;
        cmd_o.buf_src   = BufLen;
        cmd_o.blk_start = sts_i.fill_last;
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.out_shift = 1'b1;
          cmd_o.clear     = (idx_q == 3'd7);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      eom_q   <= 1'b0;
      fin_q   <= 1'b0;
      zero_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            eom_q <= eom_i;
            fin_q <= 1'b0;
            if (has_byte_i && sts_i.fill_last) begin
              state_q <= StMsgComp;
            end else if (eom_i) begin
              state_q <= StPad;
            end
          end
        end
        StMsgComp, StFinComp: begin
          if (sts_i.round_last) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (fin_q) begin
            state_q <= StOut;
            idx_q   <= '0;
          end else if (zero_q) begin
            zero_q  <= 1'b0;
            state_q <= StZero;
          end else if (eom_q) begin
            eom_q   <= 1'b0;
            state_q <= StPad;
          end else begin
            state_q <= StIdle;
          end
        end
        StPad, StZero: begin
          if (sts_i.fill_last) begin
            state_q <= StFinComp;
            zero_q  <= 1'b1;
          end else if (sts_i.fill_pre_len) begin
            state_q <= StLen;
          end else begin
            state_q <= StZero;
          end
        end
        StLen: begin
          if (sts_i.fill_last) begin
            state_q <= StFinComp;
            fin_q   <= 1'b1;
          end
        end
        StOut: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              state_q <= StIdle;
              fin_q   <= 1'b0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("out and in overlap");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_last_o) |=> in_ready_o)
    else $error("no return to idle after digest");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.round_en, cmd_o.blk_done, cmd_o.out_shift}))
    else $error("conflicting datapath commands");
`endif

endmodule

/* bench/tb.sv */
// Testbench for the SHA-256 message hasher: byte stream in, digest words checked.
`timescale 1ns / 1ps

class digest_board;
  logic [31:0] chain_q [8];
  logic [7:0]  blk_q [64];
  logic [5:0]  fill_q;
  logic [60:0] total_q;
  logic [31:0] exp_word_q [$];
  logic [2:0]  exp_idx_q [$];
  logic        exp_last_q [$];
  int          errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) chain_q[i] = sha256_pkg::InitHash[i];
    fill_q  = '0;
    total_q = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] v [8];
    logic [31:0] w [64];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 8; i++) v[i] = chain_q[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w[t] = {blk_q[4*t], blk_q[4*t+1], blk_q[4*t+2], blk_q[4*t+3]};
      end else begin
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int k = 7; k > 0; k--) v[k] = v[k-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] += v[i];
  endfunction

  function void note_beat(logic [7:0] data, logic has_byte, logic eom);
    logic [63:0] bits;
    if (has_byte) begin
      blk_q[fill_q] = data;
      total_q++;
      fill_q++;
      if (fill_q == 0) compress();
    end
    if (!eom) return;
    blk_q[fill_q] = sha256_pkg::PadByte;
    if (fill_q >= 56) begin
      for (int p = fill_q + 1; p < 64; p++) blk_q[p] = 8'h00;
      compress();
      for (int p = 0; p < 56; p++) blk_q[p] = 8'h00;
    end else begin
      for (int p = fill_q + 1; p < 56; p++) blk_q[p] = 8'h00;
    end
    bits = {total_q, 3'b000};
    for (int i = 0; i < 8; i++) blk_q[56+i] = bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      exp_word_q.push_back(chain_q[i]);
      exp_idx_q.push_back(3'(i));
      exp_last_q.push_back(i == 7);
    end
    restart();
  endfunction

  task report(string what);
    $display("mismatch: %s at %0t", what, $time);
    errors++;
  endtask

  task check_word(logic [31:0] word, logic [2:0] idx, logic last);
    logic [31:0] ew;
    logic [2:0]  ei;
    logic        el;
    if (exp_word_q.size() == 0) begin
      report("digest word with nothing pending");
      return;
    end
    ew = exp_word_q.pop_front();
    ei = exp_idx_q.pop_front();
    el = exp_last_q.pop_front();
    if (word !== ew) report($sformatf("word %h exp %h", word, ew));
    if (idx !== ei) report($sformatf("index %0d exp %0d", idx, ei));
    if (last !== el) report($sformatf("last %b exp %b", last, el));
  endtask
endclass

module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  digest_board board = new();
  bit          sending_done = 0;
  bit          hold_off = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  sha256_message_hasher_core u_top (.*);

  always #1 clk_i = ~clk_i;

  // sends one beat, gaps between random bursts
  task send_beat(logic [7:0] data, logic has_byte, logic eom);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= has_byte;
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_beat(data, has_byte, eom);
  endtask

  task send_message(int len, bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, (i == len - 1));
    end
    if (len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty, byte extremes, pad boundaries
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b1);
    send_beat(8'ha5, 1'b1, 1'b1);
    send_message(55, 0);
    send_message(56, 0);
    send_message(63, 0);
    send_message(64, 0);
    hold_off = 1;
    // random short messages
    for (int m = 0; m < 4; m++) begin
      send_message($urandom_range(0, 10), 1);
    end
    s_axis_tvalid <= 1'b0;
    sending_done = 1;
  end

  // receiver: stall pattern, one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off && idle_cycles < 200) begin
      m_axis_tready <= 1'b0;
      idle_cycles <= idle_cycles + 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0) || (idle_cycles > 5000 && idle_cycles < 5300);
      if (hold_off) idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  int quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off
        && idle_cycles < 200)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    while (board.exp_word_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
